@@ sv/zero_crossing_interpolator_macros.svh @@
// Assertion macros shared by the zero crossing interpolator modules.
`ifndef ZERO_CROSSING_INTERPOLATOR_MACROS_SVH
`define ZERO_CROSSING_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZCI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZCI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/zci_pkg.sv @@
// Shared types and constants of the zero crossing interpolator.
package zci_pkg;

    // Default coordinate width (signed fixed point, 16 fraction bits)
    localparam int COORD_WIDTH_DEF = 32;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_BOUND_MODE = '0;

    // Bound modes
    localparam logic [1:0] MODE_Y    = 2'd0;
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_CROSS   = 2'd0;
    localparam logic [1:0] STATUS_EXTRAP  = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // Commands to the shared arithmetic unit
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD_T1,
        OP_LOAD_T2,
        OP_MUL_STEP,
        OP_LOAD_DIV,
        OP_DIV_STEP
    } alu_op_t;

endpackage

@@ sv/zci_cfg.sv @@
// Register port holding the bound mode.
module zci_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [zci_pkg::PADDR_W-1:0]  paddr,
    input  logic [zci_pkg::PDATA_W-1:0]  pwdata,
    output logic [zci_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [1:0]                   bound_mode
);
    import zci_pkg::*;

    logic [1:0]         bound_mode_reg;
    logic [1:0]         bound_mode_next;
    logic [PADDR_W-3:0] reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Read and write decode
    always_comb begin
        bound_mode_next = bound_mode_reg;
        prdata          = '0;
        unique case (reg_idx)
            REG_BOUND_MODE: begin
                prdata = PDATA_W'(bound_mode_reg);
                if (wr_en) begin
                    bound_mode_next = pwdata[1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_mode_reg <= MODE_Y;
        end else begin
            bound_mode_reg <= bound_mode_next;
        end
    end

    assign bound_mode = bound_mode_reg;

endmodule

@@ sv/zci_alu.sv @@
// Shared adder unit: two shift-add multiplies and a restoring divide.
module zci_alu #(
    parameter int CW = zci_pkg::COORD_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  zci_pkg::alu_op_t cmd,
    input  logic [CW-1:0]    x_prev,
    input  logic [CW:0]      y_prev,
    input  logic [CW-1:0]    x_cur,
    input  logic [CW:0]      y_cur,
    output logic             done,
    output logic [CW-1:0]    res_x,
    output logic             res_sat
);
    import zci_pkg::*;

    localparam int ACC_W = 2 * CW + 1;
    localparam int REM_W = CW + 2;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] mcand_reg;
    logic [CW-1:0]    mplier_reg;
    logic [REM_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             term_neg_reg;
    logic             q_neg_reg;

    // Operand magnitudes
    logic [CW-1:0] xp_neg, xc_neg, xp_mag, xc_mag;
    logic [CW:0]   yp_neg, yc_neg;
    logic [CW-1:0] yp_mag, yc_mag;
    logic [CW+1:0] den, den_neg, den_mag;

    assign xp_neg  = ~x_prev + 1'b1;
    assign xc_neg  = ~x_cur + 1'b1;
    assign xp_mag  = x_prev[CW-1] ? xp_neg : x_prev;
    assign xc_mag  = x_cur[CW-1] ? xc_neg : x_cur;
    assign yp_neg  = ~y_prev + 1'b1;
    assign yc_neg  = ~y_cur + 1'b1;
    assign yp_mag  = y_prev[CW] ? yp_neg[CW-1:0] : y_prev[CW-1:0];
    assign yc_mag  = y_cur[CW] ? yc_neg[CW-1:0] : y_cur[CW-1:0];
    assign den     = {y_cur[CW], y_cur} - {y_prev[CW], y_prev};
    assign den_neg = ~den + 1'b1;
    assign den_mag = den[CW+1] ? den_neg : den;

    // The one wide adder, shared by every step
    logic [ACC_W-1:0] add_a, add_b, sum;
    logic             add_sub;
    logic [REM_W-1:0] rem_sh;

    assign rem_sh = {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};

    always_comb begin
        add_a   = acc_reg;
        add_b   = '0;
        add_sub = 1'b0;
        case (cmd)
            OP_MUL_STEP: begin
                add_b   = mcand_reg;
                add_sub = term_neg_reg;
            end
            OP_LOAD_DIV: begin
                add_a   = '0;
                add_b   = acc_reg;
                add_sub = 1'b1;
            end
            OP_DIV_STEP: begin
                add_a   = ACC_W'(rem_sh);
                add_b   = mcand_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            case (cmd) inside
                OP_LOAD_T1, OP_LOAD_T2: cnt_reg <= CNT_W'(CW);
                OP_LOAD_DIV:            cnt_reg <= CNT_W'(ACC_W);
                OP_MUL_STEP, OP_DIV_STEP: cnt_reg <= cnt_reg - 1'b1;
                default:                cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (cmd)
            OP_LOAD_T1: begin
                acc_reg      <= '0;
                mcand_reg    <= ACC_W'(xp_mag);
                mplier_reg   <= yc_mag;
                term_neg_reg <= x_prev[CW-1] ^ y_cur[CW];
            end
            OP_LOAD_T2: begin
                // second product is subtracted
                mcand_reg    <= ACC_W'(xc_mag);
                mplier_reg   <= yp_mag;
                term_neg_reg <= ~(x_cur[CW-1] ^ y_prev[CW]);
            end
            OP_MUL_STEP: begin
                if (mplier_reg[0]) begin
                    acc_reg <= sum;
                end
                mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[CW-1:1]};
            end
            OP_LOAD_DIV: begin
                // take numerator magnitude, divisor magnitude into mcand
                q_neg_reg <= acc_reg[ACC_W-1] ^ den[CW+1];
                mcand_reg <= ACC_W'(den_mag);
                rem_reg   <= '0;
                if (acc_reg[ACC_W-1]) begin
                    acc_reg <= sum;
                end
            end
            OP_DIV_STEP: begin
                if (!sum[ACC_W-1]) begin
                    rem_reg <= sum[REM_W-1:0];
                    acc_reg <= {acc_reg[ACC_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    acc_reg <= {acc_reg[ACC_W-2:0], 1'b0};
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done = (cnt_reg == '0);

    // Clip the quotient to the signed range and apply the sign
    logic          sat_pos, sat_neg;
    logic [CW-1:0] lim_pos, lim_neg, mag_clip;

    assign lim_pos  = {1'b0, {(CW-1){1'b1}}};
    assign lim_neg  = {1'b1, {(CW-1){1'b0}}};
    assign sat_pos  = |acc_reg[ACC_W-1:CW-1];
    assign sat_neg  = (|acc_reg[ACC_W-1:CW]) | (acc_reg[CW-1] & (|acc_reg[CW-2:0]));
    assign res_sat  = q_neg_reg ? sat_neg : sat_pos;
    assign mag_clip = res_sat ? (q_neg_reg ? lim_neg : lim_pos) : acc_reg[CW-1:0];
    assign res_x    = q_neg_reg ? (~mag_clip + 1'b1) : mag_clip;

`include "zero_crossing_interpolator_macros.svh"

    `ZCI_ASSERT_IMP(a_step_counted, (cmd == OP_MUL_STEP) || (cmd == OP_DIV_STEP), cnt_reg != '0, "step issued with no steps left")
    `ZCI_ASSERT_IMP(a_rem_below_div, cmd == OP_DIV_STEP, ACC_W'(rem_reg) < mcand_reg, "remainder not below divisor")
    `ZCI_ASSERT_NXT(a_acc_cleared, cmd == OP_LOAD_T1, acc_reg == '0, "accumulator not cleared")

endmodule

@@ sv/zci_ctrl.sv @@
// Sequencer: curve state, crossing decisions and the result register.
module zci_ctrl #(
    parameter int CW = zci_pkg::COORD_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       bound_mode,
    // point request
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CW-1:0]    in_x,
    input  logic [CW-1:0]    in_y,
    input  logic [CW-2:0]    in_err_low,
    input  logic [CW-2:0]    in_err_high,
    input  logic             in_last,
    // result request
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CW-1:0]    out_x,
    output logic [1:0]       out_status,
    output logic             out_sat,
    // shared unit
    output zci_pkg::alu_op_t alu_cmd,
    input  logic             alu_done,
    input  logic [CW-1:0]    alu_res_x,
    input  logic             alu_res_sat,
    output logic [CW-1:0]    op_x_prev,
    output logic [CW:0]      op_y_prev,
    output logic [CW-1:0]    op_x_cur,
    output logic [CW:0]      op_y_cur
);
    import zci_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD1,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic          have_prev_reg, have_prev_next;
    logic          crossing_done_reg, crossing_done_next;
    logic [CW-1:0] prev_x_reg, prev_x_next;
    logic [CW:0]   prev_y_reg, prev_y_next;
    logic [CW-1:0] cur_x_reg, cur_x_next;
    logic [CW:0]   cur_y_reg, cur_y_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          last_pend_reg, last_pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_x_reg, out_x_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_sat_reg, out_sat_next;

    // Tracked ordinate
    logic [CW:0] y_ext, el_ext, eh_ext, ty;

    assign y_ext  = {in_y[CW-1], in_y};
    assign el_ext = {2'b00, in_err_low};
    assign eh_ext = {2'b00, in_err_high};

    always_comb begin
        case (bound_mode)
            MODE_LOW:  ty = y_ext - el_ext;
            MODE_HIGH: ty = y_ext + eh_ext;
            default:   ty = y_ext;
        endcase
    end

    // Strict sign change against the stored point
    logic prev_neg, prev_pos, ty_neg, ty_pos, sign_change;

    assign prev_neg    = prev_y_reg[CW];
    assign prev_pos    = !prev_y_reg[CW] && (prev_y_reg != '0);
    assign ty_neg      = ty[CW];
    assign ty_pos      = !ty[CW] && (ty != '0);
    assign sign_change = (prev_neg && ty_pos) || (prev_pos && ty_neg);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Next state
    always_comb begin
        state_next         = state_reg;
        have_prev_next     = have_prev_reg;
        crossing_done_next = crossing_done_reg;
        prev_x_next        = prev_x_reg;
        prev_y_next        = prev_y_reg;
        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        res_status_next    = res_status_reg;
        last_pend_next     = last_pend_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_x_next         = out_x_reg;
        out_status_next    = out_status_reg;
        out_sat_next       = out_sat_reg;
        alu_cmd            = OP_IDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (crossing_done_reg) begin
                        // curve already answered: drop points until its end
                        if (in_last) begin
                            have_prev_next     = 1'b0;
                            crossing_done_next = 1'b0;
                            prev_x_next        = '0;
                            prev_y_next        = '0;
                        end
                    end else if (have_prev_reg && sign_change) begin
                        cur_x_next      = in_x;
                        cur_y_next      = ty;
                        res_status_next = STATUS_CROSS;
                        last_pend_next  = in_last;
                        state_next      = ST_LD1;
                    end else if (in_last) begin
                        cur_x_next     = in_x;
                        cur_y_next     = ty;
                        last_pend_next = 1'b1;
                        if (have_prev_reg && (prev_y_reg != ty)) begin
                            res_status_next = STATUS_EXTRAP;
                            state_next      = ST_LD1;
                        end else begin
                            res_status_next = STATUS_INVALID;
                            state_next      = ST_FIN;
                        end
                    end else begin
                        prev_x_next    = in_x;
                        prev_y_next    = ty;
                        have_prev_next = 1'b1;
                    end
                end
            end
            ST_LD1: begin
                alu_cmd    = OP_LOAD_T1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                if (alu_done) begin
                    alu_cmd    = OP_LOAD_T2;
                    state_next = ST_MUL2;
                end else begin
                    alu_cmd = OP_MUL_STEP;
                end
            end
            ST_MUL2: begin
                if (alu_done) begin
                    alu_cmd    = OP_LOAD_DIV;
                    state_next = ST_DIV;
                end else begin
                    alu_cmd = OP_MUL_STEP;
                end
            end
            ST_DIV: begin
                if (alu_done) begin
                    state_next = ST_FIN;
                end else begin
                    alu_cmd = OP_DIV_STEP;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    if (res_status_reg == STATUS_INVALID) begin
                        out_x_next   = '0;
                        out_sat_next = 1'b0;
                    end else begin
                        out_x_next   = alu_res_x;
                        out_sat_next = alu_res_sat;
                    end
                    if (last_pend_reg) begin
                        have_prev_next     = 1'b0;
                        crossing_done_next = 1'b0;
                        prev_x_next        = '0;
                        prev_y_next        = '0;
                    end else begin
                        crossing_done_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            have_prev_reg     <= 1'b0;
            crossing_done_reg <= 1'b0;
            prev_x_reg        <= '0;
            prev_y_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            have_prev_reg     <= have_prev_next;
            crossing_done_reg <= crossing_done_next;
            prev_x_reg        <= prev_x_next;
            prev_y_reg        <= prev_y_next;
            out_valid_reg     <= out_valid_next;
        end
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        res_status_reg <= res_status_next;
        last_pend_reg  <= last_pend_next;
        out_x_reg      <= out_x_next;
        out_status_reg <= out_status_next;
        out_sat_reg    <= out_sat_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_status = out_status_reg;
    assign out_sat    = out_sat_reg;
    assign op_x_prev  = prev_x_reg;
    assign op_y_prev  = prev_y_reg;
    assign op_x_cur   = cur_x_reg;
    assign op_y_cur   = cur_y_reg;

`include "zero_crossing_interpolator_macros.svh"

    `ZCI_ASSERT_IMP(a_done_has_prev, crossing_done_reg, have_prev_reg, "crossing marked with no stored point")
    `ZCI_ASSERT_IMP(a_solve_has_prev, state_reg == ST_LD1, have_prev_reg, "solve started with no stored point")
    `ZCI_ASSERT_IMP(a_fin_unit_idle, state_reg == ST_FIN, alu_done, "result formed while unit still busy")

endmodule

@@ sv/zero_crossing_interpolator.sv @@
// Zero crossing interpolator: a point that gives no result (stored, or
// dropped after a crossing) leaves the block ready again in the next
// cycle. A point that ends in a solve (a crossing, or the last-two-point
// extrapolation at the end of a curve) keeps s_tready low while one shared
// adder runs two shift-add multiplies of COORD_WIDTH steps each and a
// restoring divide of 2*COORD_WIDTH+1 steps, with load, hand-over and
// result states. An invalid result at the end of a curve goes straight
// to the result state. A finished result waits in the output register
// while the next point is taken; a new result that finds that register
// still full holds s_tready low until m_tready takes the old one.
module zero_crossing_interpolator #(
    parameter int COORD_WIDTH = zci_pkg::COORD_WIDTH_DEF,
    localparam int S_TDATA_W  = ((4 * COORD_WIDTH - 2 + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [zci_pkg::PADDR_W-1:0] paddr,
    input  logic [zci_pkg::PDATA_W-1:0] pwdata,
    output logic [zci_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // points
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_TDATA_W-1:0]        s_tdata,  // x_value, y_value, err_low, err_high
    input  logic                        s_tlast,  // last_point
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,  // crossing_x
    output logic [2:0]                  m_tuser   // status[1:0], saturated
);
    import zci_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [1:0]    bound_mode;
    alu_op_t       alu_cmd;
    logic          alu_done;
    logic [CW-1:0] alu_res_x;
    logic          alu_res_sat;
    logic [CW-1:0] op_x_prev, op_x_cur;
    logic [CW:0]   op_y_prev, op_y_cur;
    logic [CW-1:0] out_x;
    logic [1:0]    out_status;
    logic          out_sat;

    zci_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .bound_mode (bound_mode)
    );

    zci_ctrl #(
        .CW (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bound_mode  (bound_mode),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_x        (s_tdata[CW-1:0]),
        .in_y        (s_tdata[2*CW-1:CW]),
        .in_err_low  (s_tdata[3*CW-2:2*CW]),
        .in_err_high (s_tdata[4*CW-3:3*CW-1]),
        .in_last     (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (out_x),
        .out_status  (out_status),
        .out_sat     (out_sat),
        .alu_cmd     (alu_cmd),
        .alu_done    (alu_done),
        .alu_res_x   (alu_res_x),
        .alu_res_sat (alu_res_sat),
        .op_x_prev   (op_x_prev),
        .op_y_prev   (op_y_prev),
        .op_x_cur    (op_x_cur),
        .op_y_cur    (op_y_cur)
    );

    zci_alu #(
        .CW (CW)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .x_prev  (op_x_prev),
        .y_prev  (op_y_prev),
        .x_cur   (op_x_cur),
        .y_cur   (op_y_cur),
        .done    (alu_done),
        .res_x   (alu_res_x),
        .res_sat (alu_res_sat)
    );

    // Result packing
    assign m_tdata = M_TDATA_W'(out_x);
    assign m_tuser = {out_sat, out_status};

endmodule

@@ bench/zero_crossing_interpolator_tb.sv @@
// Self-checking bench for the zero crossing interpolator: curve streams against a local predictor.
`timescale 1ns / 100ps

module zero_crossing_interpolator_tb;
    import zci_pkg::*;

    localparam int CW        = 32;
    localparam int S_W       = 128;
    localparam int M_W       = 32;
    // busy cycles of one solve
    localparam int SOLVE_LAT = 4 * CW + 6;
    localparam int HOLD_LEN  = 1500;

    // unused encoding of the mode register, tracks y like MODE_Y
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic signed [31:0] ONE   = 32'sd65536;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic [30:0]        E_MAX = 31'h7fffffff;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        el;
        logic [30:0]        eh;
        logic               last;
    } point_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic [1:0]         status;
        logic               saturated;
    } crossing_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [2:0]       paddr    = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata  = '0;  // x_value, y_value, err_low, err_high
    logic             s_tlast  = 1'b0; // last_point
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;        // crossing_x
    logic [2:0]       m_tuser;        // status[1:0], saturated

    // predictor state
    logic [1:0]         track_mode    = MODE_Y;
    logic signed [31:0] last_x        = '0;
    logic signed [32:0] last_y        = '0;
    logic               have_last     = 1'b0;
    logic               crossing_seen = 1'b0;
    crossing_t          pending_crossings[$];

    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_go        = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_cnt       = 0;

    always #5 aclk = ~aclk;

    zero_crossing_interpolator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Root of the line through two points, truncated toward zero and clipped
    function automatic crossing_t line_root(logic signed [31:0] xa, logic signed [32:0] ya,
                                            logic signed [31:0] xb, logic signed [32:0] yb,
                                            logic [1:0] st);
        logic signed [127:0] wxa, wya, wxb, wyb, num, den, quo;
        crossing_t r;
        wxa = xa;
        wya = ya;
        wxb = xb;
        wyb = yb;
        num = wxa * wyb - wxb * wya;
        den = wyb - wya;
        quo = num / den;
        r.status    = st;
        r.saturated = 1'b0;
        if (quo > 128'sd2147483647) begin
            r.x         = Q_MAX;
            r.saturated = 1'b1;
        end else if (quo < -128'sd2147483648) begin
            r.x         = Q_MIN;
            r.saturated = 1'b1;
        end else begin
            r.x = quo[31:0];
        end
        return r;
    endfunction

    function automatic void clear_curve();
        last_x        = '0;
        last_y        = '0;
        have_last     = 1'b0;
        crossing_seen = 1'b0;
    endfunction

    // Append one expected result at the tail of the queue
    function automatic void queue_result(crossing_t c);
        pending_crossings.insert(pending_crossings.size(), c);
    endfunction

    // Expected result, if any, of one accepted point
    function automatic void predict_crossing(point_t p);
        logic signed [32:0] ty;
        ty = {p.y[31], p.y};
        if (track_mode == MODE_LOW)
            ty = $signed({p.y[31], p.y}) - $signed({2'b00, p.el});
        else if (track_mode == MODE_HIGH)
            ty = $signed({p.y[31], p.y}) + $signed({2'b00, p.eh});

        if (crossing_seen) begin
            if (p.last)
                clear_curve();
        end else if (have_last && ((last_y < 0 && ty > 0) || (last_y > 0 && ty < 0))) begin
            queue_result(line_root(last_x, last_y, p.x, ty, STATUS_CROSS));
            crossing_seen = 1'b1;
            if (p.last)
                clear_curve();
        end else if (p.last) begin
            if (have_last && last_y != ty)
                queue_result(line_root(last_x, last_y, p.x, ty, STATUS_EXTRAP));
            else
                queue_result('{x: '0, status: STATUS_INVALID, saturated: 1'b0});
            clear_curve();
        end else begin
            last_x    = p.x;
            last_y    = ty;
            have_last = 1'b1;
        end
    endfunction

    function automatic point_t pt(logic signed [31:0] x, logic signed [31:0] y,
                                  logic [30:0] el, logic [30:0] eh, logic last);
        return '{x: x, y: y, el: el, eh: eh, last: last};
    endfunction

    function automatic logic [30:0] rand_err();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return E_MAX;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(0, 1 << 16));
        endcase
    endfunction

    // Offer one point and wait for the request to be taken
    task automatic send_point(input point_t p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, p.eh, p.el, p.y, p.x};
        s_tlast  <= p.last;
        do @(posedge aclk); while (!s_tready);
        predict_crossing(p);
    endtask

    // Quiet the input, drain all results, then let a solve run out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge aclk);
        repeat (SOLVE_LAT + 8) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BOUND_MODE, 2'b00};
        pwdata  <= 32'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        track_mode = mode;
    endtask

    // One curve: mostly a sloped sweep through zero, some noise and flat runs
    task automatic send_random_curve(output int n_sent);
        int kind, len, i;
        logic signed [31:0] x0, xstep, y0, yslope;
        point_t p;
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
        x0   = $urandom;
        x0   = x0 >>> $urandom_range(0, 24);
        xstep = $urandom_range(1, 1 << 20);
        if ($urandom_range(0, 3) == 0)
            xstep = -xstep;
        y0     = $urandom_range(1, 1 << 22);
        yslope = $urandom_range(1, 1 << 21);
        if ($urandom_range(0, 1))
            y0 = -y0;
        else
            yslope = -yslope;
        for (i = 0; i < len; i++) begin
            p.x  = x0 + i * xstep;
            p.y  = y0 + i * yslope;
            p.el = rand_err();
            p.eh = rand_err();
            if (kind >= 8) begin
                p.x  = $urandom;
                p.y  = $urandom;
                p.el = 31'($urandom);
                p.eh = 31'($urandom);
            end else if (kind == 7) begin
                // equal tracked ordinates in every mode
                p.y  = y0;
                p.el = '0;
                p.eh = '0;
            end
            if ($urandom_range(0, 19) == 0)
                p.y = '0;
            p.last = (i == len - 1);
            send_point(p);
        end
        n_sent = len;
    endtask

    // Receiver: random stalls, or one long hold-off when asked
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_LEN - 1)
                hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result request with the oldest expected crossing
    always @(posedge aclk) begin : check_results
        crossing_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_crossings.size() == 0) begin
                $display("%0t: unexpected result x=%h status=%0d sat=%0b", $time,
                         m_tdata, m_tuser[1:0], m_tuser[2]);
                mismatches++;
            end else begin
                want = pending_crossings.pop_front();
                if (m_tdata != want.x || m_tuser[1:0] != want.status ||
                    m_tuser[2] != want.saturated) begin
                    $display("%0t: expected x=%h status=%0d sat=%0b, got x=%h status=%0d sat=%0b",
                             $time, want.x, want.status, want.saturated,
                             m_tdata, m_tuser[1:0], m_tuser[2]);
                    mismatches++;
                end
            end
        end
    end

    // Hand-picked curves on plain y: invalid ends, crossings, zero, saturation
    task automatic test_reference_curves();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_mode(MODE_Y);
        // lone point
        send_point(pt(ONE, ONE, '0, '0, 1'b1));
        // equal ordinates at the end
        send_point(pt('0, 5 * ONE, '0, '0, 1'b0));
        send_point(pt(ONE, 5 * ONE, '0, '0, 1'b1));
        // crossing mid curve, then points dropped until the end
        send_point(pt(ONE, -ONE, '0, '0, 1'b0));
        send_point(pt(3 * ONE, ONE, '0, '0, 1'b0));
        send_point(pt(4 * ONE, 2 * ONE, '0, '0, 1'b0));
        send_point(pt(5 * ONE, -ONE, '0, '0, 1'b1));
        // zero ordinate is no sign change; crossing on the last point
        send_point(pt('0, '0, '0, '0, 1'b0));
        send_point(pt(ONE, ONE, '0, '0, 1'b0));
        send_point(pt(2 * ONE, -ONE, '0, '0, 1'b1));
        // extrapolation through the last two points
        send_point(pt('0, ONE, '0, '0, 1'b0));
        send_point(pt(ONE, 2 * ONE, '0, '0, 1'b0));
        send_point(pt(2 * ONE, 3 * ONE, '0, '0, 1'b1));
        // extrapolation clipped at both ends
        send_point(pt(Q_MIN, 32'sd1, '0, '0, 1'b0));
        send_point(pt(Q_MAX, 32'sd2, '0, '0, 1'b1));
        send_point(pt(Q_MAX, 32'sd1, '0, '0, 1'b0));
        send_point(pt(Q_MIN, 32'sd2, '0, '0, 1'b1));
        // full-scale crossing
        send_point(pt(Q_MIN, Q_MIN, E_MAX, E_MAX, 1'b0));
        send_point(pt(Q_MAX, Q_MAX, E_MAX, E_MAX, 1'b1));
        // zero then nonzero at the end extrapolates
        send_point(pt(ONE, '0, '0, '0, 1'b0));
        send_point(pt(2 * ONE, ONE, '0, '0, 1'b1));
        wait_idle();
    endtask

    // Error bounds at full scale, then the spare mode code
    task automatic test_error_bounds();
        write_mode(MODE_LOW);
        send_point(pt(Q_MIN, Q_MIN, E_MAX, E_MAX, 1'b0));
        send_point(pt(Q_MAX, Q_MAX, '0, E_MAX, 1'b1));
        wait_idle();
        write_mode(MODE_HIGH);
        send_point(pt(Q_MAX, Q_MAX, E_MAX, E_MAX, 1'b0));
        send_point(pt(Q_MIN, Q_MIN, E_MAX, '0, 1'b1));
        wait_idle();
        write_mode(MODE_SPARE);
        send_point(pt(ONE, -ONE, 31'(5 * ONE), '0, 1'b0));
        send_point(pt(2 * ONE, ONE, '0, 31'(5 * ONE), 1'b1));
        wait_idle();
    endtask

    task automatic test_random_curves(input logic [1:0] mode, input int idle_pct,
                                      input int stall_pct, input int n_points);
        int sent, k;
        write_mode(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_points) begin
            send_random_curve(k);
            sent += k;
        end
        wait_idle();
    endtask

    // Results held back for a long stretch while short crossing curves keep coming
    task automatic test_output_backpressure();
        int i;
        write_mode(MODE_Y);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go <= 1'b1;
        for (i = 0; i < 30; i++) begin
            send_point(pt(i * ONE, -ONE - i, 31'(i), '0, 1'b0));
            send_point(pt((i + 2) * ONE, ONE + 3 * i, '0, 31'(i), 1'b1));
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reference_curves();
        test_error_bounds();
        test_random_curves(MODE_Y, 0, 0, 300);
        test_random_curves(MODE_LOW, 87, 0, 300);
        test_random_curves(MODE_HIGH, 0, 87, 300);
        test_random_curves(2'($urandom_range(0, 2)), 37, 37, 300);
        test_output_backpressure();
        if (mismatches == 0 && pending_crossings.size() == 0)
            $display("zero_crossing_interpolator: match");
        else
            $display("zero_crossing_interpolator: mismatch");
        $finish;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("zero_crossing_interpolator: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/zci_pkg.sv
sv/zci_cfg.sv
sv/zci_alu.sv
sv/zci_ctrl.sv
sv/zero_crossing_interpolator.sv
bench/zero_crossing_interpolator_tb.sv
